[src/dfr_pkg.sv]
// Shared types and constants of the delimited frame receiver.
// No dependencies; imported by every module of the block.
package dfr_pkg;

    localparam int MAX_SEQUENCE = 8;
    localparam int SACHET_BYTES = 16;
    localparam int SEQ_W        = 8 * MAX_SEQUENCE;
    localparam int SLEN_W       = 4;
    localparam int LEN_W        = 16;
    localparam int POLL_W       = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int CHUNK_W      = (SACHET_BYTES > 1) ? $clog2(SACHET_BYTES) : 1;

    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(SACHET_BYTES - 1);
    localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_SEQ = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_SEQ   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_LEN   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLL_LIM  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DATA   = 2'd1;
    localparam logic [1:0] ST_NO_START  = 2'd2;
    localparam logic [1:0] ST_NO_END    = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // One classified input item: an optional payload byte, then an optional frame end.
    typedef struct packed {
        logic              has_data;
        logic [7:0]        data;
        logic              has_end;
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
    } frame_rec_t;

endpackage

[src/dfr_front.sv]
// Front end: configuration registers, frame state and per-word classification.
// Depends on dfr_pkg.
module dfr_front
    import dfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SEQ_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    input  logic [1:0]            operation,
    input  logic [7:0]            data_byte,
    output logic                  rec_valid,
    output frame_rec_t            rec
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_START   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    logic [SEQ_W-1:0]   start_seq_reg;
    logic [SEQ_W-1:0]   end_seq_reg;
    logic [SLEN_W-1:0]  seq_len_reg;
    logic [POLL_W-1:0]  poll_limit_reg;

    phase_t             phase_reg, phase_next;
    logic [SLEN_W-1:0]  smi_reg, smi_next;
    logic [SEQ_W-1:0]   win_reg, win_next;
    logic [SLEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [POLL_W-1:0]  polls_reg, polls_next;
    logic [1:0]         err_reg, err_next;

    logic [SLEN_W-1:0]  n;
    logic [SEQ_W-1:0]   mask;
    logic [SEQ_W-1:0]   win_fill;
    logic [SEQ_W-1:0]   win_shift;
    logic [SLEN_W-1:0]  smi_inc;
    logic [7:0]         want;
    logic               spend;

    always_comb
    begin
        if (seq_len_reg == '0)
            n = SLEN_W'(1);
        else if (seq_len_reg > SLEN_W'(MAX_SEQUENCE))
            n = SLEN_W'(MAX_SEQUENCE);
        else
            n = seq_len_reg;

        for (int i = 0; i < MAX_SEQUENCE; i++)
        begin
            mask[8*i +: 8]     = (SLEN_W'(i) < n) ? 8'hff : 8'h00;
            win_fill[8*i +: 8] = (SLEN_W'(i) == fill_reg) ?
                                 (win_reg[8*i +: 8] | data_byte) : win_reg[8*i +: 8];
            if (SLEN_W'(i) == n - SLEN_W'(1))
                win_shift[8*i +: 8] = data_byte;
            else if (i < MAX_SEQUENCE - 1)
                win_shift[8*i +: 8] = win_reg[8*(i+1) +: 8];
            else
                win_shift[8*i +: 8] = 8'h00;
        end

        smi_inc = smi_reg + SLEN_W'(1);
        want    = start_seq_reg[8*smi_reg[2:0] +: 8];

        phase_next = phase_reg;
        smi_next   = smi_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        chunk_next = chunk_reg;
        polls_next = polls_reg;
        err_next   = err_reg;
        spend      = 1'b0;
        rec        = '0;

        if (in_valid)
        begin
            case (operation)
                OP_BEGIN:
                begin
                    phase_next = PH_START;
                    smi_next   = '0;
                    win_next   = '0;
                    fill_next  = '0;
                    count_next = '0;
                    chunk_next = '0;
                    polls_next = (poll_limit_reg == '0) ? POLL_W'(1) : poll_limit_reg;
                    err_next   = ST_NO_DATA;
                end
                OP_POLL:
                begin
                    spend = (phase_reg != PH_IDLE);
                end
                OP_BYTE:
                begin
                    if (phase_reg == PH_START)
                    begin
                        if (data_byte != want)
                        begin
                            err_next   = ST_NO_START;
                            phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            smi_next = smi_inc;
                            if (smi_inc >= n)
                            begin
                                phase_next = PH_PAYLOAD;
                                err_next   = ST_NO_END;
                            end
                            else
                                err_next = ST_NO_START;
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        if (fill_reg < n)
                        begin
                            win_next  = win_fill;
                            fill_next = fill_reg + SLEN_W'(1);
                        end
                        else if (count_reg == LEN_MAX)
                        begin
                            rec.has_end = 1'b1;
                            rec.status  = ST_NO_END;
                            rec.length  = LEN_MAX;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            rec.has_data = 1'b1;
                            rec.data     = win_reg[7:0];
                            count_next   = count_reg + LEN_W'(1);
                            win_next     = win_shift & mask;
                            fill_next    = n;
                        end
                        if (phase_next == PH_PAYLOAD && fill_next >= n &&
                            (win_next & mask) == (end_seq_reg & mask))
                        begin
                            rec.has_end = 1'b1;
                            rec.status  = ST_OK;
                            rec.length  = count_next;
                            phase_next  = PH_IDLE;
                        end
                    end
                    if (phase_reg != PH_IDLE && phase_next != PH_IDLE)
                    begin
                        if (chunk_reg == CHUNK_LAST)
                        begin
                            chunk_next = '0;
                            spend      = 1'b1;
                        end
                        else
                            chunk_next = chunk_reg + CHUNK_W'(1);
                    end
                end
                default: ;
            endcase

            if (spend)
            begin
                if (polls_reg <= POLL_W'(1))
                begin
                    polls_next  = '0;
                    rec.has_end = 1'b1;
                    rec.status  = err_next;
                    rec.length  = count_next;
                    phase_next  = PH_IDLE;
                end
                else
                    polls_next = polls_reg - POLL_W'(1);
            end
        end

        rec_valid = in_valid && (rec.has_data || rec.has_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seq_reg  <= '0;
            end_seq_reg    <= '0;
            seq_len_reg    <= SLEN_W'(2);
            poll_limit_reg <= POLL_W'(1000);
            phase_reg      <= PH_IDLE;
            smi_reg        <= '0;
            win_reg        <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            chunk_reg      <= '0;
            polls_reg      <= '0;
            err_reg        <= ST_NO_DATA;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_START_SEQ: start_seq_reg  <= cfg_wdata;
                    CFG_END_SEQ:   end_seq_reg    <= cfg_wdata;
                    CFG_SEQ_LEN:   seq_len_reg    <= cfg_wdata[SLEN_W-1:0];
                    CFG_POLL_LIM:  poll_limit_reg <= cfg_wdata[POLL_W-1:0];
                    default: ;
                endcase
            end
            phase_reg <= phase_next;
            smi_reg   <= smi_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            chunk_reg <= chunk_next;
            polls_reg <= polls_next;
            err_reg   <= err_next;
        end
    end

endmodule

[src/dfr_queue.sv]
// Record queue between front and back end.
// Depends on dfr_pkg.
module dfr_queue
    import dfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  frame_rec_t wr_rec,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output frame_rec_t rd_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    frame_rec_t        store [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_rec   = store[rptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
        if (do_rd)
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store[wptr_reg] <= wr_rec;
    end

endmodule

[src/dfr_back.sv]
// Back end: expands each queued record into one or two result words.
// Depends on dfr_pkg.
module dfr_back
    import dfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    input  frame_rec_t        rec,
    output logic              rec_take,
    output logic              empty,
    input  logic              pop,
    output logic              result_kind,
    output logic [7:0]        payload_byte,
    output logic [1:0]        status,
    output logic [LEN_W-1:0]  payload_length,
    output logic              last
);

    logic sent_data_reg, sent_data_next;
    logic show_data;
    logic fire;

    assign empty     = !rec_valid;
    assign show_data = rec.has_data && !sent_data_reg;
    assign fire      = pop && rec_valid;

    always_comb
    begin
        if (show_data)
        begin
            result_kind    = KIND_PAYLOAD;
            payload_byte   = rec.data;
            status         = ST_OK;
            payload_length = '0;
            last           = !rec.has_end;
        end
        else
        begin
            result_kind    = KIND_END;
            payload_byte   = 8'h00;
            status         = rec.status;
            payload_length = rec.length;
            last           = 1'b1;
        end

        rec_take       = fire && !(show_data && rec.has_end);
        sent_data_next = sent_data_reg;
        if (fire)
            sent_data_next = show_data && rec.has_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sent_data_reg <= 1'b0;
        else
            sent_data_reg <= sent_data_next;
    end

endmodule

[src/delimited_frame_receiver_core.sv]
// Top level of the delimited frame receiver: front end, record queue, back end.
// Depends on dfr_pkg, dfr_front, dfr_queue, dfr_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | push / full        | operation, data_byte
//  result   | empty / pop        | result_kind, payload_byte, status,
//           |                    | payload_length, last
//  config   | cfg_we             | cfg_addr, cfg_wdata
//
// One input word per cycle, while full is low, is classified in the cycle it is
// taken; its record is queued. A record with a payload byte and a frame end
// gives two result words, one per cycle while pop is high. Reset clears all
// frame state and loads register defaults. full rises only when the QUEUE_DEPTH
// record queue is full; pop stalls hold the head word on the result ports.
module delimited_frame_receiver_core
    import dfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SEQ_W-1:0]      cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            operation,
    input  logic [7:0]            data_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  result_kind,
    output logic [7:0]            payload_byte,
    output logic [1:0]            status,
    output logic [LEN_W-1:0]      payload_length,
    output logic                  last
);

    logic       accept;
    logic       front_valid;
    frame_rec_t front_rec;
    logic       head_valid;
    frame_rec_t head_rec;
    logic       head_take;

    assign accept = push && !full;

    dfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (accept),
        .operation (operation),
        .data_byte (data_byte),
        .rec_valid (front_valid),
        .rec       (front_rec)
    );

    dfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_rec   (front_rec),
        .full     (full),
        .rd_en    (head_take),
        .rd_valid (head_valid),
        .rd_rec   (head_rec)
    );

    dfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (head_valid),
        .rec            (head_rec),
        .rec_take       (head_take),
        .empty          (empty),
        .pop            (pop),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

[src/dfr_checker.sv]
// Port-level checks of the delimited frame receiver, bound to the top level.
// Depends on dfr_pkg and delimited_frame_receiver_core.
module dfr_checker
    import dfr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic                  result_kind,
    input logic [7:0]            payload_byte,
    input logic [1:0]            status,
    input logic [LEN_W-1:0]      payload_length,
    input logic                  last
);

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_END) |-> last)
        else $error("frame end word without last");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_PAYLOAD) |-> (status == ST_OK && payload_length == '0))
        else $error("payload word carries status or length");

    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result_kind == KIND_PAYLOAD && !last) |=>
        (!empty && result_kind == KIND_END && last))
        else $error("payload word not followed by its frame end");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(payload_byte) &&
        $stable(status) && $stable(payload_length) && $stable(last)))
        else $error("stalled result word changed");

endmodule

bind delimited_frame_receiver_core dfr_checker u_dfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .status         (status),
    .payload_length (payload_length),
    .last           (last)
);

[test/delimited_frame_receiver_core_test.sv]
// Self-checking testbench of delimited_frame_receiver_core: directed frames, then random
// frame traffic under several register settings and idle patterns.
// Depends on dfr_pkg and the RTL of the block; the scoreboard class predicts every result word.
module delimited_frame_receiver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int SETTINGS_PER_PHASE = 3;
    localparam int WORDS_PER_SETTING  = 80;
    localparam int MAX_PRINTED        = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_IDLE, RX_START, RX_PAYLOAD, RX_DISCARD} rx_phase_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
        logic             last;
    } frame_word_t;

    class frame_scoreboard;
        frame_word_t      deframed_words[$];
        logic [SEQ_W-1:0] start_seq  = '0;
        logic [SEQ_W-1:0] end_seq    = '0;
        logic [3:0]       len_reg    = 4'd2;
        logic [15:0]      poll_reg   = 16'd1000;
        rx_phase_t        phase      = RX_IDLE;
        int               match_idx  = 0;
        logic [SEQ_W-1:0] window     = '0;
        int               fill       = 0;
        logic [LEN_W-1:0] count      = '0;
        int               chunk      = 0;
        logic [15:0]      polls_left = '0;
        logic [1:0]       last_err   = ST_NO_DATA;
        int               ends_seen[4];
        int               words_checked = 0;

        function new();
            foreach (ends_seen[i]) ends_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [SEQ_W-1:0] value);
            case (idx)
                CFG_START_SEQ: start_seq = value;
                CFG_END_SEQ:   end_seq   = value;
                CFG_SEQ_LEN:   len_reg   = value[3:0];
                CFG_POLL_LIM:  poll_reg  = value[15:0];
                default: ;
            endcase
        endfunction

        function int seq_bytes();
            int n;
            n = len_reg;
            if (n < 1) n = 1;
            if (n > MAX_SEQUENCE) n = MAX_SEQUENCE;
            return n;
        endfunction

        function logic [SEQ_W-1:0] window_mask(int n);
            if (n >= MAX_SEQUENCE) return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function void add_word(logic kind, logic [7:0] data, logic [1:0] st,
                               logic [LEN_W-1:0] len);
            frame_word_t w;
            w.kind   = kind;
            w.data   = data;
            w.status = st;
            w.length = len;
            w.last   = 1'b0;
            deframed_words.push_back(w);
        endfunction

        function void close_frame(logic [1:0] st);
            add_word(KIND_END, 8'd0, st, count);
            phase = RX_IDLE;
        endfunction

        function void spend_poll();
            if (polls_left <= 16'd1) begin
                polls_left = '0;
                close_frame(last_err);
            end
            else begin
                polls_left--;
            end
        endfunction

        function void absorb_input(logic [1:0] op, logic [7:0] b);
            int          n;
            int          first;
            logic [7:0]  want;
            frame_word_t tail;
            n     = seq_bytes();
            first = deframed_words.size();
            if (op == OP_BEGIN) begin
                phase      = RX_START;
                match_idx  = 0;
                window     = '0;
                fill       = 0;
                count      = '0;
                chunk      = 0;
                polls_left = (poll_reg == 16'd0) ? 16'd1 : poll_reg;
                last_err   = ST_NO_DATA;
                return;
            end
            if (op == OP_UNUSED || phase == RX_IDLE) return;
            if (op == OP_POLL) begin
                spend_poll();
            end
            else begin
                if (phase == RX_START) begin
                    want = start_seq[8 * (match_idx & 7) +: 8];
                    if (b != want) begin
                        last_err = ST_NO_START;
                        phase    = RX_DISCARD;
                    end
                    else begin
                        match_idx++;
                        if (match_idx >= n) begin
                            phase    = RX_PAYLOAD;
                            last_err = ST_NO_END;
                        end
                        else begin
                            last_err = ST_NO_START;
                        end
                    end
                end
                else if (phase == RX_PAYLOAD) begin
                    if (fill < n) begin
                        window = window | ({56'd0, b} << (8 * fill));
                        fill++;
                    end
                    else if (count == LEN_MAX) begin
                        close_frame(ST_NO_END);
                    end
                    else begin
                        add_word(KIND_PAYLOAD, window[7:0], ST_OK, '0);
                        count++;
                        window = ((window >> 8) | ({56'd0, b} << (8 * (n - 1))))
                                 & window_mask(n);
                        fill = n;
                    end
                    if (phase == RX_PAYLOAD && fill >= n &&
                        (window & window_mask(n)) == (end_seq & window_mask(n)))
                        close_frame(ST_OK);
                end
                if (phase != RX_IDLE) begin
                    chunk++;
                    if (chunk >= SACHET_BYTES) begin
                        chunk = 0;
                        spend_poll();
                    end
                end
            end
            if (deframed_words.size() > first) begin
                tail = deframed_words.pop_back();
                tail.last = 1'b1;
                deframed_words.push_back(tail);
            end
        endfunction

        function bit match_result(logic kind, logic [7:0] data, logic [1:0] st,
                                  logic [LEN_W-1:0] len, logic lst, output string why);
            frame_word_t e;
            why = "";
            if (deframed_words.size() == 0) begin
                why = $sformatf("unexpected word kind %0d byte %02h status %0d len %0d",
                                kind, data, st, len);
                return 1'b1;
            end
            e = deframed_words.pop_front();
            words_checked++;
            if (e.kind == KIND_END) ends_seen[e.status]++;
            if (kind !== e.kind || data !== e.data || st !== e.status ||
                len !== e.length || lst !== e.last) begin
                why = $sformatf({"got kind %0d byte %02h status %0d len %0d last %0d, ",
                                 "want kind %0d byte %02h status %0d len %0d last %0d"},
                                kind, data, st, len, lst,
                                e.kind, e.data, e.status, e.length, e.last);
                return 1'b1;
            end
            return 1'b0;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [SEQ_W-1:0]      cfg_wdata;
    logic                  push;
    logic                  full;
    logic [1:0]            operation;
    logic [7:0]            data_byte;
    logic                  empty;
    logic                  pop;
    logic                  result_kind;
    logic [7:0]            payload_byte;
    logic [1:0]            status;
    logic [LEN_W-1:0]      payload_length;
    logic                  last;

    frame_scoreboard board;
    int    errors      = 0;
    int    cycle_count = 0;
    int    words_sent  = 0;
    int    send_idle   = 0;
    int    recv_stall  = 0;
    int    send_pct[4] = '{0, 74, 0, 32};
    int    recv_pct[4] = '{0, 0, 74, 32};
    string mismatch_text;

    delimited_frame_receiver_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .data_byte      (data_byte),
        .empty          (empty),
        .pop            (pop),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .payload_length (payload_length),
        .last           (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // result side: pop decided at the falling edge, word taken at the rising edge
    always @(negedge clk)
    begin
        if (rst_n) pop <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (board.match_result(result_kind, payload_byte, status, payload_length,
                                   last, mismatch_text))
                report(mismatch_text);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        operation <= op;
        data_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        board.absorb_input(op, b);
        words_sent++;
        @(negedge clk);
    endtask

    // wait until every predicted word is out, plus a margin for words still in flight
    task automatic settle();
        push <= 1'b0;
        while (board.deframed_words.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [SEQ_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        board.set_reg(idx, value);
    endtask

    task automatic write_settings(input logic [SEQ_W-1:0] s, e, len, poll);
        settle();
        write_reg(CFG_START_SEQ, s);
        write_reg(CFG_END_SEQ, e);
        write_reg(CFG_SEQ_LEN, len);
        write_reg(CFG_POLL_LIM, poll);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [SEQ_W-1:0] pick_pattern();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic pick_settings(input int idx);
        logic [SEQ_W-1:0] sv;
        logic [SEQ_W-1:0] ev;
        logic [SEQ_W-1:0] lv;
        logic [SEQ_W-1:0] pv;
        int               lc;
        int               pc;
        sv = pick_pattern();
        ev = pick_pattern();
        lv = {$urandom, $urandom};
        pv = {$urandom, $urandom};
        // first settings walk the extremes, later ones are drawn at random
        lc = (idx < 5) ? idx : $urandom_range(0, 4);
        pc = (idx < 5) ? idx : $urandom_range(0, 5);
        case (lc)
            0:       lv[3:0] = 4'd1;
            1:       lv[3:0] = 4'd8;
            2:       lv[3:0] = 4'd0;
            3:       lv[3:0] = 4'd15;
            default: lv[3:0] = 4'($urandom_range(2, 7));
        endcase
        case (pc)
            0:       pv[15:0] = 16'd0;
            1:       pv[15:0] = 16'hFFFF;
            2:       pv[15:0] = 16'd1;
            3:       pv[15:0] = 16'($urandom_range(2, 6));
            default: pv[15:0] = 16'($urandom_range(7, 1000));
        endcase
        write_settings(sv, ev, lv, pv);
    endtask

    task automatic run_traffic(input int budget);
        int stop;
        int n;
        int sel;
        int plen;
        int good;
        int r;
        stop = words_sent + budget;
        while (words_sent < stop)
        begin
            sel = $urandom_range(0, 99);
            n   = board.seq_bytes();
            if (sel < 70)
            begin
                send_word(OP_BEGIN, 8'($urandom));
                for (int i = 0; i < n; i++) send_word(OP_BYTE, board.start_seq[8 * i +: 8]);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                for (int i = 0; i < plen; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8) send_word(OP_POLL, 8'($urandom));
                    else if (r < 10) send_word(OP_UNUSED, 8'($urandom));
                    send_word(OP_BYTE, 8'($urandom));
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    for (int i = 0; i < n; i++) send_word(OP_BYTE, board.end_seq[8 * i +: 8]);
                end
            end
            else if (sel < 80)
            begin
                // broken start delimiter
                send_word(OP_BEGIN, 8'($urandom));
                good = $urandom_range(0, n - 1);
                for (int i = 0; i < good; i++) send_word(OP_BYTE, board.start_seq[8 * i +: 8]);
                send_word(OP_BYTE, board.start_seq[8 * good +: 8] ^ 8'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 4)) send_word(OP_BYTE, 8'($urandom));
            end
            else if (sel < 90)
            begin
                send_word(OP_BEGIN, 8'($urandom));
                repeat ($urandom_range(1, 8)) send_word(OP_POLL, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_START_SEQ;
        cfg_wdata = '0;
        push      = 1'b0;
        pop       = 1'b0;
        operation = OP_BEGIN;
        data_byte = 8'd0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: zero delimiters of two bytes
        send_word(OP_BEGIN, 8'h00);
        repeat (4) send_word(OP_BYTE, 8'h00);
        // receiver idle: ignored
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_POLL, 8'h55);
        send_word(OP_UNUSED, 8'hFF);

        write_settings(64'h0123_4567_89AB_5A7E, 64'hFEDC_BA98_7654_0A0D, 64'd2, 64'd3);
        // polls only, then a broken start
        send_word(OP_BEGIN, 8'hFF);
        repeat (3) send_word(OP_POLL, 8'h00);
        send_word(OP_BEGIN, 8'h00);
        send_word(OP_BYTE, 8'h7E);
        send_word(OP_BYTE, 8'h11);
        repeat (3) send_word(OP_POLL, 8'h00);
        // restart mid-frame, stray code 3, end never seen
        send_word(OP_BEGIN, 8'h00);
        send_word(OP_BYTE, 8'h7E);
        send_word(OP_BEGIN, 8'h00);
        send_word(OP_BYTE, 8'h7E);
        send_word(OP_BYTE, 8'h5A);
        send_word(OP_UNUSED, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h01);
        repeat (3) send_word(OP_POLL, 8'h00);

        // end delimiter completed by the byte that closes a chunk
        write_settings(64'h0123_4567_89AB_5A7E, 64'hFEDC_BA98_7654_0A0D, 64'd2, 64'd1);
        send_word(OP_BEGIN, 8'h00);
        send_word(OP_BYTE, 8'h7E);
        send_word(OP_BYTE, 8'h5A);
        for (int i = 0; i < 12; i++) send_word(OP_BYTE, 8'(8'h20 + i));
        send_word(OP_BYTE, 8'h0D);
        send_word(OP_BYTE, 8'h0A);

        for (int p = 0; p < 4; p++)
        begin
            send_idle  = send_pct[p];
            recv_stall = recv_pct[p];
            for (int k = 0; k < SETTINGS_PER_PHASE; k++)
            begin
                pick_settings(p * SETTINGS_PER_PHASE + k);
                run_traffic(WORDS_PER_SETTING);
            end
        end

        settle();
        if (board.deframed_words.size() != 0)
            report($sformatf("%0d words never arrived", board.deframed_words.size()));
        $display("Sent %0d input words over %0d cycles; %0d result words checked.",
                 words_sent, cycle_count, board.words_checked);
        $display("Frame ends: ok %0d, no data %0d, start missing %0d, end missing %0d.",
                 board.ends_seen[ST_OK], board.ends_seen[ST_NO_DATA],
                 board.ends_seen[ST_NO_START], board.ends_seen[ST_NO_END]);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
